### rtl/bpk_pkg.sv
// Package for the LSB-first bit packer.
// Holds the item, result and job types and shared constants; no dependencies.
package bpk_pkg;

  localparam int ValueBits       = 32;
  localparam int ByteBits        = 8;
  localparam int HeldBits        = 7;
  localparam int MaxBytes        = ValueBits / ByteBits;
  localparam int MaxWidthDefault = 32;
  localparam int QueueDepthDflt  = 2;

  typedef enum logic {
    KIND_PUT   = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef struct packed {
    logic                 kind;
    logic [ValueBits-1:0] value;
    logic [5:0]           width;
  } in_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                last;
  } out_t;

  // Work for the back end: up to four bytes, low byte first, and how many.
  typedef struct packed {
    logic [ValueBits-1:0] bytes;
    logic [2:0]           count;
  } job_t;

endpackage

### rtl/bpk_front.sv
// Front end of the bit packer: accepts items, merges them with the held bits
// and hands whole bytes to the job queue. Depends on bpk_pkg.
module bpk_front
  import bpk_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  item_i,
  output logic job_valid_o,
  output job_t job_o
);

  localparam int Lim     = (MAX_WIDTH < ValueBits) ? MAX_WIDTH : ValueBits;
  localparam int AccBits = ValueBits + HeldBits;

  logic [HeldBits-1:0]  partial_q, partial_d;
  logic [2:0]           held_q, held_d;
  logic [5:0]           w_eff;
  logic [ValueBits-1:0] mask, masked;
  logic [AccBits-1:0]   acc, acc_sh;
  logic [5:0]           total;
  logic [2:0]           n_bytes;

  always_comb begin
    // Saturate wide widths, then drop value bits above the width.
    w_eff = (item_i.width > 6'(Lim)) ? 6'(Lim) : item_i.width;
    if (w_eff >= 6'(ValueBits)) begin
      mask = '1;
    end else begin
      mask = ~({ValueBits{1'b1}} << w_eff[4:0]);
    end
    masked  = item_i.value & mask;
    acc     = {{ValueBits{1'b0}}, partial_q} | ({{HeldBits{1'b0}}, masked} << held_q);
    total   = 6'(held_q) + w_eff;
    n_bytes = total[5:3];
    acc_sh  = acc >> {n_bytes, 3'b000};
  end

  always_comb begin
    partial_d   = partial_q;
    held_d      = held_q;
    job_valid_o = 1'b0;
    job_o.bytes = acc[ValueBits-1:0];
    job_o.count = n_bytes;
    if (accept_i) begin
      if (item_i.kind == KIND_FLUSH) begin
        job_o.bytes = {{(ValueBits-HeldBits){1'b0}}, partial_q};
        job_o.count = 3'd1;
        job_valid_o = (held_q != 3'd0);
        partial_d   = '0;
        held_d      = '0;
      end else begin
        job_valid_o = (n_bytes != 3'd0);
        held_d      = total[2:0];
        partial_d   = acc_sh[HeldBits-1:0] & ~({HeldBits{1'b1}} << total[2:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      held_q    <= '0;
    end else begin
      partial_q <= partial_d;
      held_q    <= held_d;
    end
  end

  // Bits above the held count stay zero.
  a_partial_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (partial_q >> held_q) == '0) else $error("stray bits above held count");

  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> (job_o.count != 3'd0 && job_o.count <= 3'(MaxBytes)))
    else $error("job with bad byte count");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.kind == KIND_FLUSH) |=> held_q == 3'd0)
    else $error("flush left bits held");

endmodule

### rtl/bpk_queue.sv
// Short job queue between the packer front and back ends.
// Register storage, first in first out. Depends on bpk_pkg for job_t.
module bpk_queue
  import bpk_pkg::*;
#(
  parameter int DEPTH = QueueDepthDflt
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output job_t rd_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH)) else $error("queue count above depth");

  a_write_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o) else $error("write into full queue");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance");

endmodule

### rtl/bpk_back.sv
// Back end of the bit packer: takes jobs from the queue and drains their
// bytes one per cycle from the output register while pop_i is high. Depends on bpk_pkg.
module bpk_back
  import bpk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  job_t q_data_i,
  output logic q_rd_o,
  output logic empty_o,
  input  logic pop_i,
  output out_t out_o
);

  logic [ValueBits-1:0] bytes_q, bytes_d;
  logic [2:0]           count_q, count_d;
  logic                 take, load;

  assign empty_o        = (count_q == 3'd0);
  assign take           = pop_i && !empty_o;
  assign out_o.out_byte = bytes_q[ByteBits-1:0];
  assign out_o.last     = (count_q == 3'd1);

  // Refill when idle or as the last byte of the current job leaves.
  assign load   = (empty_o || (take && count_q == 3'd1)) && !q_empty_i;
  assign q_rd_o = load;

  always_comb begin
    bytes_d = bytes_q;
    count_d = count_q;
    if (load) begin
      bytes_d = q_data_i.bytes;
      count_d = q_data_i.count;
    end else if (take) begin
      bytes_d = bytes_q >> ByteBits;
      count_d = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(MaxBytes)) else $error("byte count out of range");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && count_q == 3'd1 && q_empty_i) |=> empty_o)
    else $error("output not empty after last byte");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> $stable(count_q) && $stable(bytes_q))
    else $error("output changed while stalled");

endmodule

### rtl/lsb_first_bit_packer.sv
// LSB-first variable-width bit packer, top level.
// Items enter through a queue-style port (push/full) with an in_t payload:
//   kind 0 = put the low width bits of value (width saturates to the
//   smaller of MAX_WIDTH and 32), kind 1 = flush the held partial byte.
// Bytes leave through a queue-style port (empty/pop) with an out_t payload;
//   last marks the final byte produced by one item.
// A put that completes no byte, and a flush with no bits held, produce
//   nothing; they only update the held bits.
// Path: the job of an item is written into the job queue when the item is
//   accepted, then moves into the output register once that register is free;
//   the output register drives its first byte on out_o.
// Throughput: the output register drains one byte per cycle while the receiver
//   pops, and a put yields at most four bytes; the front takes one item per cycle
//   as long as the QUEUE_DEPTH-entry job queue has room, and full rises otherwise.
// When the receiver stalls, the output byte holds, the job queue fills and
//   then full holds the sender off.
// Reset clears the held bits and empties the queue and the output register
//   (their data bits are not reset); nothing is pending afterwards.
module lsb_first_bit_packer
  import bpk_pkg::*;
#(
  parameter int MAX_WIDTH   = MaxWidthDefault,
  parameter int QUEUE_DEPTH = QueueDepthDflt
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  output logic empty,
  input  logic pop,
  output out_t out_o
);

  logic accept;
  logic job_valid;
  job_t job, q_data;
  logic q_empty, q_rd;

  assign accept = push && !full;

  bpk_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  bpk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_valid),
    .wr_data_i (job),
    .full_o    (full),
    .rd_i      (q_rd),
    .empty_o   (q_empty),
    .rd_data_o (q_data)
  );

  bpk_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_data),
    .q_rd_o    (q_rd),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_o     (out_o)
  );

endmodule
